// ===== sv/rag_pkg.sv =====
// Shared types, constants and codes of the region auto gain unit.
package rag_pkg;

   localparam int WINDOW_ORIGIN = 33940;
   localparam int WINDOW_COLS   = 236;
   localparam int WINDOW_ROWS   = 119;
   localparam int LINE_STRIDE   = 512;
   localparam int APPLY_COLS    = 506;
   localparam int APPLY_ROWS    = 244;

   localparam int WIN_ROW0    = WINDOW_ORIGIN / LINE_STRIDE;
   localparam int WIN_COL0    = WINDOW_ORIGIN % LINE_STRIDE;
   localparam int WINDOW_AREA = WINDOW_ROWS * WINDOW_COLS;

   localparam int COORD_W    = 9;
   localparam int PIXEL_W    = 8;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 13;
   localparam int SUM_W      = 23;
   localparam int TARGET_W   = 7;
   localparam int AVG_W      = 9;
   localparam int LEVEL_W    = 15;
   localparam int DVD_W      = LEVEL_W + GAIN_FRAC;
   localparam int DSR_W      = 15;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // window average as sum * AVG_RECIP >> AVG_SHIFT, exact for every SUM_W-bit sum
   localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_AREA);
   localparam int RECIP_W   = SUM_W + 1;
   localparam longint AVG_RECIP_VAL =
      ((longint'(1) << AVG_SHIFT) + longint'(WINDOW_AREA) - 1) / longint'(WINDOW_AREA);
   localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_VAL);

   localparam int QUEUE_DEPTH = 4;

   localparam logic [GAIN_W-1:0]   GAIN_ONE      = 16'd8192;
   localparam logic [GAIN_W-1:0]   GAIN_MAX      = 16'd40960;
   localparam logic [TARGET_W-1:0] TARGET_RESET  = 7'd18;
   localparam logic [LEVEL_W-1:0]  FULL_SCALE    = 15'd255;
   localparam logic [DSR_W-1:0]    PERCENT_SCALE = 15'd100;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OVR_EN   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OVR_GAIN = 2'd2;

   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_APPLY   = 1'b1;

   typedef struct packed {
      logic [TARGET_W-1:0] target_percent;
      logic                override_enable;
      logic [GAIN_W-1:0]   override_gain;
   } cfg_type;

   typedef struct packed {
      logic               is_gain;
      logic               scale;
      logic [PIXEL_W-1:0] pixel;
      logic [SUM_W-1:0]   sum;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LEVEL,
      BK_QUOT,
      BK_REPORT
   } back_state_type;

endpackage

// ===== sv/rag_fifo.sv =====
// Short command queue between the front end and the back end.
module rag_fifo
   import rag_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_data,
   input  logic            pop,
   output queue_entry_type pop_data,
   output logic            full,
   output logic            empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/rag_front.sv =====
// Front end: accepts requests, sums window pixels and queues commands.
module rag_front
   import rag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output queue_entry_type       q_data
);

   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [PIXEL_W-1:0] pixel;
   logic               accept;
   logic               in_window;
   logic               in_apply;
   logic [SUM_W-1:0]   summed;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   assign row   = req_tdata[COORD_W-1:0];
   assign col   = req_tdata[2*COORD_W-1:COORD_W];
   assign pixel = req_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign in_window = ({1'b0, row} >= 10'(WIN_ROW0)) &&
                      ({1'b0, row} <  10'(WIN_ROW0 + WINDOW_ROWS)) &&
                      ({1'b0, col} >= 10'(WIN_COL0)) &&
                      ({1'b0, col} <  10'(WIN_COL0 + WINDOW_COLS));
   assign in_apply  = ({1'b0, row} < 10'(APPLY_ROWS)) &&
                      ({1'b0, col} < 10'(APPLY_COLS));

   assign summed = in_window ? sum_ff + SUM_W'(pixel) : sum_ff;

   always_comb begin
      sum_in          = sum_ff;
      q_push          = 1'b0;
      q_data.is_gain  = (req_tuser == REQ_MEASURE);
      q_data.scale    = in_apply;
      q_data.pixel    = pixel;
      q_data.sum      = summed;
      if (accept) begin
         if (req_tuser == REQ_MEASURE) begin
            sum_in = req_tlast ? '0 : summed;
            q_push = req_tlast;
         end else begin
            q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== sv/rag_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rag_div
   import rag_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic [DSR_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   trial;
   logic             fits;

   assign trial    = {rem_ff[DSR_W-1:0], quo_ff[DVD_W-1]};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, dsr_ff} : trial;
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== sv/rag_back.sv =====
// Back end: gain computation, pixel scaling and the result register.
module rag_back
   import rag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  queue_entry_type       q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   back_state_type state_ff, state_in;

   logic [GAIN_W-1:0]  active_gain_ff, active_gain_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_is_gain_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic [GAIN_W-1:0]  rsp_gain_ff;

   logic               out_free;
   logic               load_pixel;
   logic               load_report;
   logic [GAIN_W-1:0]  gain_use;
   logic [LEVEL_W-1:0] level;
   logic [DSR_W-1:0]   avg100;
   logic               bright;
   logic [SUM_W+RECIP_W-1:0] avg_product;
   logic [PIXEL_W+GAIN_W-1:0] product;
   logic [PIXEL_W+GAIN_W-GAIN_FRAC-1:0] scaled;
   logic [PIXEL_W-1:0] pixel_res;

   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DSR_W-1:0] div_divisor;
   logic             div_done;
   logic [DVD_W-1:0] div_quotient;

   rag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign gain_use = cfg.override_enable ? cfg.override_gain : active_gain_ff;
   assign level    = LEVEL_W'(cfg.target_percent) * FULL_SCALE;
   assign avg100   = DSR_W'(avg_ff) * PERCENT_SCALE;
   assign bright   = (avg100 >= level);

   assign avg_product  = q_data.sum * AVG_RECIP;
   assign div_dividend = {level, {GAIN_FRAC{1'b0}}};
   assign div_divisor  = avg100;

   assign product   = q_data.pixel * gain_use;
   assign scaled    = product[PIXEL_W+GAIN_W-1:GAIN_FRAC];
   assign pixel_res = !q_data.scale ? q_data.pixel :
                      (scaled > (PIXEL_W+GAIN_W-GAIN_FRAC)'({PIXEL_W{1'b1}})) ?
                      {PIXEL_W{1'b1}} : scaled[PIXEL_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_data.is_gain) begin
               state_in = BK_LEVEL;
            end
         end
         BK_LEVEL: begin
            state_in = (bright || avg_ff == '0) ? BK_REPORT : BK_QUOT;
         end
         BK_QUOT: begin
            if (div_done) begin
               state_in = BK_REPORT;
            end
         end
         BK_REPORT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop          = 1'b0;
      load_pixel     = 1'b0;
      load_report    = 1'b0;
      div_start      = 1'b0;
      avg_in         = avg_ff;
      active_gain_in = active_gain_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_data.is_gain) begin
                  q_pop  = 1'b1;
                  avg_in = avg_product[AVG_SHIFT +: AVG_W];
               end else if (out_free) begin
                  q_pop      = 1'b1;
                  load_pixel = 1'b1;
               end
            end
         end
         BK_LEVEL: begin
            if (bright) begin
               active_gain_in = GAIN_ONE;
            end else if (avg_ff == '0) begin
               active_gain_in = GAIN_MAX;
            end else begin
               div_start = 1'b1;
            end
         end
         BK_QUOT: begin
            if (div_done) begin
               active_gain_in = (div_quotient > DVD_W'(GAIN_MAX)) ?
                                GAIN_MAX : div_quotient[GAIN_W-1:0];
            end
         end
         BK_REPORT: begin
            load_report = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_pixel || load_report) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         active_gain_ff <= GAIN_ONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_gain_ff <= active_gain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
      if (load_pixel) begin
         rsp_is_gain_ff <= 1'b0;
         rsp_pixel_ff   <= pixel_res;
         rsp_gain_ff    <= gain_use;
      end else if (load_report) begin
         rsp_is_gain_ff <= 1'b1;
         rsp_pixel_ff   <= '0;
         rsp_gain_ff    <= gain_use;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_is_gain_ff;
   assign rsp_tdata  = {rsp_gain_ff, rsp_pixel_ff};

endmodule

// ===== sv/region_auto_gain_unit.sv =====
// Top level of the region auto gain unit: control registers and the front/back split.
// Takes one request per cycle while the command queue has room. Measure pixels are summed in
// the front end; apply pixels are scaled combinationally by the back end and leave through a
// result register, so a steady stream of apply pixels runs at one per cycle while the result
// side takes them and no gain is being computed. A measure pixel marked as frame end makes
// the back end compute a new gain: the window average comes from a reciprocal multiplication,
// and unless the target is already met or the average is zero a 28-step bit-serial division
// follows. The back end registers the average, decides in its level state, divides in its
// quotient state if needed and loads the report into the result register from its report
// state once the result side is free. Meanwhile the front end keeps taking requests until the
// command queue (QUEUE_DEPTH entries) is full. Control registers are written at once through
// the csr port and hold their values from reset: target 18 %, override off, override 1.0.
module region_auto_gain_unit
   import rag_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pixel_row, pixel_col, pixel_in, zero fill
   input  logic                  req_tuser,  // req_type
   input  logic                  req_tlast,  // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pixel_out, gain_out
   output logic                  rsp_tuser,  // is_gain
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_empty;
   queue_entry_type q_push_data;
   queue_entry_type q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TARGET:   cfg_in.target_percent  = csr_wdata[TARGET_W-1:0];
            CSR_OVR_EN:   cfg_in.override_enable = csr_wdata[0];
            CSR_OVR_GAIN: cfg_in.override_gain   = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_percent  <= TARGET_RESET;
         cfg_ff.override_enable <= 1'b0;
         cfg_ff.override_gain   <= GAIN_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   rag_fifo #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   rag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/rag_checker.sv =====
// Port-level checks of the region auto gain unit and their binding.
module rag_checker
   import rag_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_reset_frees_req: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request side not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transfer changed");

   a_report_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[PIXEL_W-1:0] == '0)
      else $error("gain report carries a pixel");

endmodule

bind region_auto_gain_unit rag_checker u_rag_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
